// ===== src/bdiu_pkg.sv =====
// shared types and constants for the birth-death interval update pipeline
`default_nettype none

package bdiu_pkg;

    // fixed-point constants
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int unsigned TAYLOR_ORDER = 14;
    localparam int unsigned DIV_STAGES = 64;

    // rounded-up reciprocals for the taylor term divides, ceil(2^s / n)
    localparam logic [32:0] RECIP [2:14] = '{
        33'd4294967296, 33'd5726623062, 33'd4294967296, 33'd6871947674,
        33'd5726623062, 33'd4908534053, 33'd4294967296, 33'd7635497416,
        33'd6871947674, 33'd6247225158, 33'd5726623062, 33'd5286113596,
        33'd4908534053
    };
    localparam logic [5:0] RSHIFT [2:14] = '{
        6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd35,
        6'd36, 6'd36, 6'd36, 6'd36, 6'd36, 6'd36
    };

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_SAT      = 2'd2
    } status_t;

    // per-item state carried down the pipeline
    typedef struct packed {
        logic [31:0] dt;
        logic [31:0] lam;
        logic [31:0] mu;
        logic [31:0] d0;
        logic [31:0] e0;
        logic [31:0] onee;
        logic [31:0] dm;
        logic        swap;
        logic [32:0] g;
        logic [63:0] wm;
        logic        wneg;
        logic        wzero;
        logic [63:0] ne;
        logic [31:0] gd0;
        logic [63:0] eq;
        logic        eovf;
        logic [63:0] t1;
        logic        dovf;
    } item_t;

endpackage

`default_nettype wire

// ===== src/bdiu_mulw.sv =====
// two-stage 64x64 multiplier built from four 32x32 partial products
`default_nettype none

module bdiu_mulw (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           vld_in,
    input  bdiu_pkg::item_t     item_in,
    input  wire logic [63:0]    op_a,
    input  wire logic [63:0]    op_b,
    output logic                vld_out,
    output bdiu_pkg::item_t     item_out,
    output logic [127:0]        prod
);
    import bdiu_pkg::*;

    logic [1:0]   vld_reg;
    item_t        item_reg [0:1];
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], vld_in};
        end
    end

    // partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= item_in;
            p00_reg <= op_a[31:0] * op_b[31:0];
            p01_reg <= op_a[31:0] * op_b[63:32];
            p10_reg <= op_a[63:32] * op_b[31:0];
            p11_reg <= op_a[63:32] * op_b[63:32];
        end
    end

    // sum of partial products
    always_comb begin
        prod_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                  + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[1] <= item_reg[0];
            prod_reg <= prod_next;
        end
    end

    assign vld_out  = vld_reg[1];
    assign item_out = item_reg[1];
    assign prod     = prod_reg;

endmodule

`default_nettype wire

// ===== src/bdiu_div.sv =====
// pipelined restoring divider, 128 by 64 bits, one quotient bit a stage
`default_nettype none

module bdiu_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           vld_in,
    input  bdiu_pkg::item_t     item_in,
    input  wire logic [127:0]   num,
    input  wire logic [63:0]    den,
    output logic                vld_out,
    output bdiu_pkg::item_t     item_out,
    output logic [63:0]         quo,
    output logic                ovf
);
    import bdiu_pkg::*;

    logic [DIV_STAGES:0] vld_reg;
    item_t               item_reg [0:DIV_STAGES];
    logic [63:0]         den_reg  [0:DIV_STAGES];
    logic [63:0]         rem_reg  [0:DIV_STAGES];
    logic [63:0]         lo_reg   [0:DIV_STAGES];
    logic [63:0]         quo_reg  [0:DIV_STAGES];
    logic                ovf_reg  [0:DIV_STAGES];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-1:0], vld_in};
        end
    end

    // entry stage: overflow check and load of the partial remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= item_in;
            den_reg[0]  <= den;
            rem_reg[0]  <= num[127:64];
            lo_reg[0]   <= num[63:0];
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= (den == 64'd0) || (num[127:64] >= den);
        end
    end

    // one compare and subtract per stage
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_step
        logic [64:0] shifted;
        logic [64:0] diff;
        logic        take;

        always_comb begin
            shifted = {rem_reg[s-1], lo_reg[s-1][63]};
            diff    = shifted - {1'b0, den_reg[s-1]};
            take    = shifted >= {1'b0, den_reg[s-1]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[s] <= item_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                lo_reg[s]   <= {lo_reg[s-1][62:0], 1'b0};
                rem_reg[s]  <= take ? diff[63:0] : shifted[63:0];
                quo_reg[s]  <= {quo_reg[s-1][62:0], take};
            end
        end
    end

    assign vld_out  = vld_reg[DIV_STAGES];
    assign item_out = item_reg[DIV_STAGES];
    assign quo      = quo_reg[DIV_STAGES];
    assign ovf      = ovf_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ===== src/bdiu_exp.sv =====
// decay factor g = e^(-|mu-lambda|*dt): range reduction and taylor series
`default_nettype none

module bdiu_exp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           vld_in,
    input  bdiu_pkg::item_t     item_in,
    output logic                vld_out,
    output bdiu_pkg::item_t     item_out
);
    import bdiu_pkg::*;

    localparam int unsigned RED_N = 6;
    localparam int unsigned TAY_N = 2 * (TAYLOR_ORDER - 1);

    // range reduction stage contents
    typedef struct packed {
        logic [36:0] rem;
        logic [5:0]  k;
        logic        big;
    } red_t;

    // series stage contents
    typedef struct packed {
        logic [31:0] f;
        logic [5:0]  k;
        logic        big;
        logic [31:0] t;
        logic [34:0] pos;
        logic [34:0] neg;
    } tay_t;

    logic [RED_N:0] rvld_reg;
    red_t           red_reg  [0:RED_N];
    item_t          ritem_reg [0:RED_N];
    logic [TAY_N:0] tvld_reg;
    tay_t           tay_reg  [0:TAY_N];
    item_t          titem_reg [0:TAY_N];
    logic           gvld_reg;
    item_t          gitem_reg;
    item_t          gitem_next;
    logic [63:0]    yprod;
    logic [34:0]    gdiff;
    logic [32:0]    g_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvld_reg <= '0;
            tvld_reg <= '0;
            gvld_reg <= 1'b0;
        end else if (en) begin
            rvld_reg <= {rvld_reg[RED_N-1:0], vld_in};
            tvld_reg <= {tvld_reg[TAY_N-1:0], rvld_reg[RED_N]};
            gvld_reg <= tvld_reg[TAY_N];
        end
    end

    // exponent argument y = |mu-lambda|*dt, kept to 2^-32
    assign yprod = item_in.dm * item_in.dt;

    always_ff @(posedge aclk) begin
        if (en) begin
            ritem_reg[0]   <= item_in;
            red_reg[0].rem <= yprod[52:16];
            red_reg[0].k   <= '0;
            red_reg[0].big <= |yprod[63:53];
        end
    end

    // y = k*ln2 + f, one bit of k per stage
    for (genvar j = 1; j <= RED_N; j++) begin : g_red
        localparam int unsigned B = RED_N - j;
        logic [36:0] sub_val;
        logic        take;

        always_comb begin
            sub_val = {5'd0, LN2_Q32} << B;
            take    = red_reg[j-1].rem >= sub_val;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ritem_reg[j]   <= ritem_reg[j-1];
                red_reg[j].big <= red_reg[j-1].big;
                red_reg[j].rem <= take ? red_reg[j-1].rem - sub_val : red_reg[j-1].rem;
                red_reg[j].k   <= red_reg[j-1].k | (take ? 6'(1 << B) : 6'd0);
            end
        end
    end

    // first series term is f itself
    always_ff @(posedge aclk) begin
        if (en) begin
            titem_reg[0]   <= ritem_reg[RED_N];
            tay_reg[0].f   <= red_reg[RED_N].rem[31:0];
            tay_reg[0].k   <= red_reg[RED_N].k;
            tay_reg[0].big <= red_reg[RED_N].big;
            tay_reg[0].t   <= red_reg[RED_N].rem[31:0];
            tay_reg[0].pos <= 35'h1_0000_0000;
            tay_reg[0].neg <= {3'd0, red_reg[RED_N].rem[31:0]};
        end
    end

    // term n: multiply by f, then divide by n through its reciprocal
    for (genvar n = 2; n <= TAYLOR_ORDER; n++) begin : g_term
        localparam int unsigned IA = 2 * (n - 2) + 1;
        localparam int unsigned IB = IA + 1;
        logic [63:0] xprod;
        logic [64:0] rprod;
        logic [31:0] t_new;
        tay_t        ta_next;
        tay_t        tb_next;

        always_comb begin
            xprod     = tay_reg[IA-1].t * tay_reg[IA-1].f;
            rprod     = tay_reg[IA].t * RECIP[n];
            t_new     = 32'(rprod >> RSHIFT[n]);
            ta_next   = tay_reg[IA-1];
            ta_next.t = xprod[63:32];
            tb_next   = tay_reg[IA];
            tb_next.t = t_new;
            if ((n % 2) == 1) begin
                tb_next.neg = tay_reg[IA].neg + {3'd0, t_new};
            end else begin
                tb_next.pos = tay_reg[IA].pos + {3'd0, t_new};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                titem_reg[IA] <= titem_reg[IA-1];
                tay_reg[IA]   <= ta_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                titem_reg[IB] <= titem_reg[IA];
                tay_reg[IB]   <= tb_next;
            end
        end
    end

    // g = (pos - neg) >> k, zero on underflow
    always_comb begin
        gdiff = tay_reg[TAY_N].pos - tay_reg[TAY_N].neg;
        if (tay_reg[TAY_N].big || (tay_reg[TAY_N].neg >= tay_reg[TAY_N].pos)) begin
            g_next = '0;
        end else begin
            g_next = 33'(gdiff >> tay_reg[TAY_N].k);
        end
        gitem_next   = titem_reg[TAY_N];
        gitem_next.g = g_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gitem_reg <= gitem_next;
        end
    end

    assign vld_out  = gvld_reg;
    assign item_out = gitem_reg;

endmodule

`default_nettype wire

// ===== src/bdiu_denom.sv =====
// common denominator W and the g-scaled numerator terms
`default_nettype none

module bdiu_denom (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           vld_in,
    input  bdiu_pkg::item_t     item_in,
    output logic                vld_out,
    output bdiu_pkg::item_t     item_out
);
    import bdiu_pkg::*;

    logic [4:0]  vld_reg;
    item_t       item_reg [0:4];
    item_t       item0_next, item3_next, item4_next;
    logic [63:0] p_reg [1:3];
    logic [63:0] le_reg;
    logic [63:0] qm_reg [2:3];
    logic        qneg_reg [2:4];
    logic [63:0] pv_lo_reg, pv_hi_reg, ne_lo_reg, ne_hi_reg, d0p_reg;
    logic [63:0] pt_reg, qt_reg;
    logic [63:0] ms;
    logic [63:0] sv;
    logic [63:0] sv_prod;
    logic [63:0] sne_prod;
    logic [63:0] sd0_prod;
    logic [63:0] w_next;
    logic        wneg_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], vld_in};
        end
    end

    // products lambda*(1-E0), lambda*E0, (1-E0)*|lambda-mu|
    always_comb begin
        item0_next    = item_in;
        item0_next.ne = item_in.onee * item_in.dm;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= item0_next;
            p_reg[1]    <= item_in.lam * item_in.onee;
            le_reg      <= item_in.lam * item_in.e0;
        end
    end

    // magnitude and sign of lambda*E0 - mu
    assign ms = {1'b0, item_reg[0].mu, 31'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[1] <= item_reg[0];
            p_reg[2]    <= p_reg[1];
            qneg_reg[2] <= le_reg < ms;
            qm_reg[2]   <= (le_reg < ms) ? ms - le_reg : le_reg - ms;
        end
    end

    // partial products of the scaling by g
    assign sv = item_reg[1].swap ? p_reg[2] : qm_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[2] <= item_reg[1];
            p_reg[3]    <= p_reg[2];
            qm_reg[3]   <= qm_reg[2];
            qneg_reg[3] <= qneg_reg[2];
            pv_lo_reg   <= sv[31:0] * item_reg[1].g[31:0];
            pv_hi_reg   <= sv[63:32] * item_reg[1].g[31:0];
            ne_lo_reg   <= item_reg[1].ne[31:0] * item_reg[1].g[31:0];
            ne_hi_reg   <= item_reg[1].ne[63:32] * item_reg[1].g[31:0];
            d0p_reg     <= item_reg[1].d0 * item_reg[1].g[31:0];
        end
    end

    // (v*g) >> 32, with the g = 1.0 bit added back
    always_comb begin
        sv_prod  = pv_hi_reg + {32'd0, pv_lo_reg[63:32]}
                 + (item_reg[2].g[32] ? (item_reg[2].swap ? p_reg[3] : qm_reg[3]) : 64'd0);
        sne_prod = ne_hi_reg + {32'd0, ne_lo_reg[63:32]}
                 + (item_reg[2].g[32] ? item_reg[2].ne : 64'd0);
        sd0_prod = {32'd0, d0p_reg[63:32]}
                 + (item_reg[2].g[32] ? {32'd0, item_reg[2].d0} : 64'd0);
        item3_next     = item_reg[2];
        item3_next.gd0 = sd0_prod[31:0];
        item3_next.ne  = item_reg[2].swap ? sne_prod : item_reg[2].ne;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[3]     <= item3_next;
            pt_reg          <= item_reg[2].swap ? sv_prod : p_reg[3];
            qt_reg          <= item_reg[2].swap ? qm_reg[3] : sv_prod;
            qneg_reg[4]     <= qneg_reg[3];
        end
    end

    // W as sign and magnitude
    always_comb begin
        if (!qneg_reg[4]) begin
            w_next    = pt_reg + qt_reg;
            wneg_next = 1'b0;
        end else if (pt_reg >= qt_reg) begin
            w_next    = pt_reg - qt_reg;
            wneg_next = 1'b0;
        end else begin
            w_next    = qt_reg - pt_reg;
            wneg_next = 1'b1;
        end
        item4_next       = item_reg[3];
        item4_next.wm    = w_next;
        item4_next.wneg  = wneg_next;
        item4_next.wzero = w_next == 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[4] <= item4_next;
        end
    end

    assign vld_out  = vld_reg[4];
    assign item_out = item_reg[4];

endmodule

`default_nettype wire

// ===== src/birth_death_interval_update.sv =====
// top level: closed-form birth-death interval update, one item per cycle while the output is not stalled
//
//  port group   dir  payload (low bit first)
//  s_axis_*     in   delta_t, birth_rate, death_rate, start_density, start_extinction
//  m_axis_*     out  end_density, end_extinction, status
//
// accepts one item every cycle unless the output stalls; the pipeline runs through the
// 35-stage exponential, the denominator, three 65-stage dividers and two multipliers.
// aresetn clears only the valid bits; the data registers are left as they are.
// a stall at the output freezes every stage at once, so nothing is lost or repeated.
// s_axis_tready is low only while a result waits in the output register.
`default_nettype none

module birth_death_interval_update (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // delta_t[31:0], birth_rate[63:32], death_rate[95:64],
    // start_density[127:96], start_extinction[159:128]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // end_density[31:0], end_extinction[63:32], status[65:64], zero fill above
    output logic [71:0]       m_axis_tdata
);
    import bdiu_pkg::*;

    logic        en;
    logic        in_vld_reg;
    item_t       in_item_reg;
    item_t       in_item_next;
    logic [31:0] e0_in;
    logic [31:0] lam_in;
    logic [31:0] mu_in;

    logic        g_vld, w_vld, e_vld, m1_vld, d1_vld, m2_vld, d2_vld;
    item_t       g_item, w_item, e_item, m1_item, d1_item, m2_item, d2_item;
    item_t       e_merged, d1_merged;
    logic [63:0] e_quo, d1_quo, d2_quo;
    logic        e_ovf, d1_ovf, d2_ovf;
    logic [127:0] m1_prod, m2_prod;
    logic [63:0] rm_m1, rm_m2;

    logic        out_vld_reg;
    logic [31:0] dens_reg, ext_reg;
    status_t     stat_reg;
    logic [31:0] dens_next, ext_next;
    status_t     stat_next;
    logic [63:0] q_e;
    logic        eneg;

    // whole pipeline advances unless a result is held at the output
    assign en            = m_axis_tready || !out_vld_reg;
    assign s_axis_tready = en;

    // input stage: clamp E0, form 1-E0 and |lambda-mu|
    assign lam_in = s_axis_tdata[63:32];
    assign mu_in  = s_axis_tdata[95:64];
    assign e0_in  = (s_axis_tdata[159:128] > ONE_Q31) ? ONE_Q31 : s_axis_tdata[159:128];

    always_comb begin
        in_item_next      = '0;
        in_item_next.dt   = s_axis_tdata[31:0];
        in_item_next.lam  = lam_in;
        in_item_next.mu   = mu_in;
        in_item_next.d0   = s_axis_tdata[127:96];
        in_item_next.e0   = e0_in;
        in_item_next.onee = ONE_Q31 - e0_in;
        in_item_next.swap = mu_in > lam_in;
        in_item_next.dm   = (mu_in > lam_in) ? mu_in - lam_in : lam_in - mu_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_item_reg <= in_item_next;
        end
    end

    // decay factor
    bdiu_exp u_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (in_vld_reg),
        .item_in  (in_item_reg),
        .vld_out  (g_vld),
        .item_out (g_item)
    );

    // denominator and scaled terms
    bdiu_denom u_denom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (g_vld),
        .item_in  (g_item),
        .vld_out  (w_vld),
        .item_out (w_item)
    );

    // extinction quotient (N_E << 31) / |W|
    bdiu_div u_div_e (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (w_vld),
        .item_in  (w_item),
        .num      ({33'd0, w_item.ne, 31'd0}),
        .den      (w_item.wm),
        .vld_out  (e_vld),
        .item_out (e_item),
        .quo      (e_quo),
        .ovf      (e_ovf)
    );

    always_comb begin
        e_merged      = e_item;
        e_merged.eq   = e_quo;
        e_merged.eovf = e_ovf;
    end

    // gD0 * r
    assign rm_m1 = {1'b0, e_merged.dm, 31'd0};

    bdiu_mulw u_mul1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (e_vld),
        .item_in  (e_merged),
        .op_a     ({32'd0, e_merged.gd0}),
        .op_b     (rm_m1),
        .vld_out  (m1_vld),
        .item_out (m1_item),
        .prod     (m1_prod)
    );

    // first density quotient
    bdiu_div u_div_d1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (m1_vld),
        .item_in  (m1_item),
        .num      (m1_prod),
        .den      (m1_item.wm),
        .vld_out  (d1_vld),
        .item_out (d1_item),
        .quo      (d1_quo),
        .ovf      (d1_ovf)
    );

    always_comb begin
        d1_merged      = d1_item;
        d1_merged.t1   = d1_quo;
        d1_merged.dovf = d1_ovf;
    end

    // t1 * r
    assign rm_m2 = {1'b0, d1_merged.dm, 31'd0};

    bdiu_mulw u_mul2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (d1_vld),
        .item_in  (d1_merged),
        .op_a     (d1_merged.t1),
        .op_b     (rm_m2),
        .vld_out  (m2_vld),
        .item_out (m2_item),
        .prod     (m2_prod)
    );

    // second density quotient
    bdiu_div u_div_d2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (m2_vld),
        .item_in  (m2_item),
        .num      (m2_prod),
        .den      (m2_item.wm),
        .vld_out  (d2_vld),
        .item_out (d2_item),
        .quo      (d2_quo),
        .ovf      (d2_ovf)
    );

    // final saturation and status
    always_comb begin
        stat_next = STAT_OK;
        q_e       = d2_item.eovf ? 64'hFFFF_FFFF_FFFF_FFFF : d2_item.eq;
        eneg      = (d2_item.ne != 64'd0) && (d2_item.swap != d2_item.wneg);
        if (eneg) begin
            ext_next = ONE_Q31;
            if (q_e != 64'd0) begin
                stat_next = STAT_SAT;
            end
        end else if (q_e > {32'd0, ONE_Q31}) begin
            ext_next  = '0;
            stat_next = STAT_SAT;
        end else begin
            ext_next = ONE_Q31 - q_e[31:0];
        end
        if (d2_item.dovf || d2_ovf || (d2_quo[63:32] != 32'd0)) begin
            dens_next = 32'hFFFF_FFFF;
            stat_next = STAT_SAT;
        end else begin
            dens_next = d2_quo[31:0];
        end
        if (d2_item.wzero) begin
            dens_next = 32'hFFFF_FFFF;
            ext_next  = ONE_Q31;
            stat_next = STAT_ZERO_DEN;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dens_reg <= dens_next;
            ext_reg  <= ext_next;
            stat_reg <= stat_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, stat_reg, ext_reg, dens_reg};

    // checks
    a_zero_den_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (stat_reg == STAT_ZERO_DEN))
            |-> (dens_reg == 32'hFFFF_FFFF) && (ext_reg == ONE_Q31))
        else $error("zero denominator result not saturated");

    a_ext_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (ext_reg <= ONE_Q31))
        else $error("extinction probability above one");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (stat_reg == STAT_OK) || (stat_reg == STAT_ZERO_DEN)
                          || (stat_reg == STAT_SAT))
        else $error("undefined status code");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(dens_reg)
                                              && $stable(ext_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== bench/birth_death_interval_update_checker.sv =====
// checker: watches both channels, predicts each result and compares it
`default_nettype none

module birth_death_interval_update_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [71:0]  m_axis_tdata,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bdiu_pkg::*;

    typedef struct packed {
        logic [31:0] dens;
        logic [31:0] ext;
        status_t     status;
    } interval_result_t;

    interval_result_t expected_results[$];

    // e^-y in q1.32, y in q16.48
    function automatic logic [63:0] decay_factor(input logic [63:0] y48);
        logic [63:0] y, k, f, t, pos, neg;
        y = y48 >> 16;
        t = 64'h1_0000_0000;
        pos = 64'h1_0000_0000;
        neg = 0;
        if (y >= (64'd32 << 32)) begin
            return 0;
        end
        k = y / LN2_Q32;
        f = y - k * LN2_Q32;
        for (int n = 1; n <= TAYLOR_ORDER; n++) begin
            t = ((t * f) >> 32) / n;
            if (n % 2 == 1) neg += t;
            else pos += t;
        end
        if (neg >= pos) return 0;
        return (pos - neg) >> k;
    endfunction

    // (v * g) >> 32, kept to 64 bits
    function automatic logic [63:0] scale_by(input logic [63:0] v, input logic [63:0] g);
        logic [127:0] prod;
        prod = {64'd0, v} * {64'd0, g};
        return prod[95:32];
    endfunction

    // truncated quotient; ok low when divisor is zero or quotient exceeds 64 bits
    function automatic logic divide_ok(input logic [127:0] num, input logic [63:0] den,
                                       output logic [63:0] quo);
        logic [127:0] q;
        quo = '1;
        if (den == 0 || num[127:64] >= den) return 0;
        q = num / {64'd0, den};
        quo = q[63:0];
        return 1;
    endfunction

    function automatic interval_result_t predict_interval(input logic [159:0] data);
        logic [63:0] dt, lam, mu, d0, e0, onee, dm, g, p, le, ms, qm, pt, qt, wm;
        logic [63:0] ne, q, gd0, rm, t1, dens, ext;
        logic swap, qneg, wneg, eneg, ok;
        interval_result_t r;
        dt = data[31:0];
        lam = data[63:32];
        mu = data[95:64];
        d0 = data[127:96];
        e0 = data[159:128];
        r.status = STAT_OK;
        if (e0 > ONE_Q31) e0 = ONE_Q31;
        onee = ONE_Q31 - e0;
        swap = mu > lam;
        dm = swap ? mu - lam : lam - mu;
        g = decay_factor(dm * dt);
        p = lam * onee;
        le = lam * e0;
        ms = mu << 31;
        qneg = le < ms;
        qm = qneg ? ms - le : le - ms;
        pt = swap ? scale_by(p, g) : p;
        qt = swap ? qm : scale_by(qm, g);
        wneg = 0;
        if (!qneg) wm = pt + qt;
        else if (pt >= qt) wm = pt - qt;
        else begin
            wm = qt - pt;
            wneg = 1;
        end
        // zero denominator
        if (wm == 0) begin
            r.dens = '1;
            r.ext = ONE_Q31;
            r.status = STAT_ZERO_DEN;
            return r;
        end
        // extinction
        ne = onee * dm;
        if (swap) ne = scale_by(ne, g);
        if (!divide_ok({64'd0, ne} << 31, wm, q)) q = '1;
        eneg = (ne != 0) && (swap != wneg);
        if (eneg) begin
            ext = ONE_Q31;
            if (q != 0) r.status = STAT_SAT;
        end else if (q > ONE_Q31) begin
            ext = 0;
            r.status = STAT_SAT;
        end else begin
            ext = ONE_Q31 - q;
        end
        // density
        gd0 = scale_by(d0, g);
        rm = dm << 31;
        ok = divide_ok({64'd0, gd0} * {64'd0, rm}, wm, t1);
        if (ok) ok = divide_ok({64'd0, t1} * {64'd0, rm}, wm, dens);
        if (!ok || dens > 64'hFFFF_FFFF) begin
            dens = 64'hFFFF_FFFF;
            r.status = STAT_SAT;
        end
        r.dens = dens[31:0];
        r.ext = ext[31:0];
        return r;
    endfunction

    // predict on input items, compare on result items
    always @(posedge aclk) begin
        interval_result_t want;
        if (!aresetn) begin
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_interval(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.dens ||
                        m_axis_tdata[63:32] !== want.ext ||
                        m_axis_tdata[65:64] !== want.status)
                        fail_count <= fail_count + 1;
                    if (m_axis_tdata[31:0] !== want.dens)
                        $error("end_density expected %h actual %h",
                               want.dens, m_axis_tdata[31:0]);
                    if (m_axis_tdata[63:32] !== want.ext)
                        $error("end_extinction expected %h actual %h",
                               want.ext, m_axis_tdata[63:32]);
                    if (m_axis_tdata[65:64] !== want.status)
                        $error("status expected %0d actual %0d",
                               want.status, m_axis_tdata[65:64]);
                end
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/birth_death_interval_update_test.sv =====
// testbench top: stimulus, output back-pressure and verdict
`default_nettype none

module birth_death_interval_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 240;
    localparam int RANDOM_ITEMS = 900;
    localparam logic [31:0] ONE = 32'h8000_0000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [71:0]  m_axis_tdata;
    int           fail_count;
    int           pending_count;
    int           results_taken = 0;

    always #1 aclk = ~aclk;

    birth_death_interval_update dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    birth_death_interval_update_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // offer one interval item after a gap, hold it until accepted
    task automatic send_interval(input logic [31:0] dt, lam, mu, d0, e0, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {e0, d0, mu, lam, dt};
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // rate drawn from full range, small realistic range or near the other rate
    function automatic logic [31:0] draw_rate(input logic [31:0] other);
        unique case ($urandom_range(0, 4))
            0: return $urandom;
            1: return other;
            2: return other + $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    // receiver: random hold-off per item, none in alternate runs of 150 results, one long stall to back up the pipeline
    initial begin
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (results_taken == 40) hold = 800;
            else if ((results_taken / 150) % 2 == 1) hold = 0;
            else hold = $urandom_range(0, 12);
            if (hold > 0) begin
                m_axis_tready <= 0;
                repeat (hold) @(posedge aclk);
            end
            m_axis_tready <= 1;
            @(negedge aclk);
            while (!m_axis_tvalid) @(negedge aclk);
            @(posedge aclk);
            results_taken++;
        end
    end

    // run limit
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and verdict
    initial begin
        logic [31:0] dt, lam, mu, d0, e0;
        int gap;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, equal rates, out-of-range e0, saturation
        send_interval(0, 0, 0, 0, 0, 0);
        send_interval('1, '1, '1, '1, '1, 0);
        send_interval(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, ONE, ONE, 0);
        send_interval(32'h0100_0000, 32'h0100_0000, 32'h0200_0000, ONE, 0, 0);
        send_interval(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, ONE, 32'h4000_0000, 0);
        send_interval(32'h0100_0000, 32'h0300_0000, 32'h0100_0000, ONE, 32'hFFFF_FFFF, 1);
        send_interval('1, 32'h0100_0000, 32'h0200_0000, ONE, ONE, 0);
        send_interval('1, 32'h0200_0000, 32'h0100_0000, ONE, ONE, 0);
        send_interval('1, '1, 0, '1, 0, 2);
        send_interval('1, 0, '1, '1, 0, 0);
        send_interval(32'h0000_0001, 32'h0000_0002, 32'h0000_0001, '1, 32'h7FFF_FFFF, 0);
        send_interval(32'h0080_0000, 32'h0180_0000, 32'h0080_0000, '1, 32'h2000_0000, 0);
        send_interval(32'h0080_0000, 32'h0080_0000, 32'h0180_0000, '1, 32'h6000_0000, 3);
        send_interval(32'h2000_0000, 32'h0010_0000, 32'h0008_0000, '1, 32'h8000_0001, 0);
        send_interval(32'h0100_0000, 0, 32'h0100_0000, '1, ONE, 0);
        send_interval(32'h0100_0000, 32'h0100_0000, 0, '1, 0, 0);
        send_interval(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 0);
        send_interval(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h2AAA_AAAA, 0);

        // random intervals
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            dt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000);
            lam = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000);
            mu = draw_rate(lam);
            d0 = $urandom;
            e0 = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, ONE);
            gap = ((i / 120) % 3 == 2) ? 0 : $urandom_range(0, 12);
            send_interval(dt, lam, mu, d0, e0, gap);
        end
        s_axis_tvalid <= 0;

        // drain
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 50) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/bdiu_pkg.sv
src/bdiu_mulw.sv
src/bdiu_div.sv
src/bdiu_exp.sv
src/bdiu_denom.sv
src/birth_death_interval_update.sv
bench/birth_death_interval_update_checker.sv
bench/birth_death_interval_update_test.sv
